/* hdl/pfmr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfmr_pkg - shared types and constants for the pressure resultant block
// Field widths, stream packing, register indexes, status codes and the
// step numbering of the shared multiplier sequence.
// ----------------------------------------------------------------------------
package pfmr_pkg;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int SUM_W      = 64;
    localparam int LOAD_W     = 63;
    localparam int CROSS_W    = 97;

    // Stream and configuration port widths
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 456;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Output item packing
    localparam int OUT_LOAD_LSB   = 384;
    localparam int OUT_STATUS_LSB = 447;
    localparam int OUT_USED_W     = 449;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [LOAD_W-1:0]  load_t;
    typedef logic [CROSS_W-1:0] cross_t;

    localparam sum_t  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam sum_t  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam load_t LOAD_MAX = {LOAD_W{1'b1}};

    // Status codes, ordered by severity
    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_ZERO_AREA = 2'd1;
    localparam status_t ST_OVERFLOW  = 2'd2;

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_PRESSURE = 3'd0;
    localparam cfg_idx_t CFG_INWARD   = 3'd1;
    localparam cfg_idx_t CFG_REF_X    = 3'd2;
    localparam cfg_idx_t CFG_REF_Y    = 3'd3;
    localparam cfg_idx_t CFG_REF_Z    = 3'd4;

    // Multiplier step numbering
    typedef logic [4:0] step_t;
    localparam step_t STEP_FORCE0     = 5'd0;
    localparam step_t STEP_SQUARE0    = 5'd3;
    localparam step_t STEP_CROSS0     = 5'd6;
    localparam step_t STEP_CROSS_LAST = 5'd17;
    localparam step_t STEP_LOAD       = 5'd18;

endpackage

/* hdl/pressure_force_moment_resultant.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_force_moment_resultant - force, moment and load of a facet stream
// Sums pressure force, moment about a reference point and scalar normal load
// over surface facets, and emits the totals on the facet marked last.
// ----------------------------------------------------------------------------
// Usage:
//   Facets enter on the s_ stream: six Q16.16 coordinates in s_tdata and the
//   last-facet mark on s_tlast. Pressure, direction and reference point are
//   written over the cfg_ channel (always ready) while the block is idle.
//   One 32x32 multiplier is shared by nineteen products per facet (three
//   forces, three area squares, twelve cross-product halves, one load), and
//   a shift/subtract square root runs in between. s_tready is high only when
//   idle, so a facet is accepted only once the previous one is finished.
//   On a last facet the totals are registered onto m_ in the wrap state, and
//   the sums and status clear for the next run.
//   The result sits in an output register; the next facet is taken while it
//   waits. If the receiver still stalls when the next result is ready, the
//   block holds that result and stays busy until the register frees.
//   Reset clears the sums, status, registers and output valid.
// ----------------------------------------------------------------------------
module pressure_force_moment_resultant #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // area_x, area_y, area_z, centroid_x, centroid_y, centroid_z
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pfmr_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    // force_x/y/z, moment_x/y/z, normal_load, status, zero fill
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pfmr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfmr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfmr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int TOP_LO = pfmr_pkg::SUM_W - 1 + FRAC_BITS;
    localparam int HI_W   = pfmr_pkg::CROSS_W - TOP_LO;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_LOAD,
        S_FIN,
        S_WRAP
    } state_t;

    typedef struct packed {
        logic            ovf;
        pfmr_pkg::sum_t  val;
    } sat_t;

    // Control and accumulator state
    state_t             state_reg, state_next;
    pfmr_pkg::step_t    step_reg, step_next;
    pfmr_pkg::step_t    tag_reg, tag_next;
    logic               tag_valid_reg, tag_valid_next;
    logic               mfin_valid_reg, mfin_valid_next;
    logic [1:0]         mfin_idx_reg, mfin_idx_next;
    pfmr_pkg::coord_t   pressure_reg, pressure_next;
    logic               inward_reg, inward_next;
    pfmr_pkg::coord_t   ref_reg [0:2];
    pfmr_pkg::coord_t   ref_next [0:2];
    pfmr_pkg::sum_t     fsum_reg [0:2];
    pfmr_pkg::sum_t     fsum_next [0:2];
    pfmr_pkg::sum_t     msum_reg [0:2];
    pfmr_pkg::sum_t     msum_next [0:2];
    pfmr_pkg::load_t    lsum_reg, lsum_next;
    pfmr_pkg::status_t  status_reg, status_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [pfmr_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Per-facet datapath registers
    pfmr_pkg::coord_t   amag_reg [0:2];
    pfmr_pkg::coord_t   amag_next [0:2];
    logic               aneg_reg [0:2];
    logic               aneg_next [0:2];
    pfmr_pkg::coord_t   lmag_reg [0:2];
    pfmr_pkg::coord_t   lmag_next [0:2];
    logic               lneg_reg [0:2];
    logic               lneg_next [0:2];
    logic               last_reg, last_next;
    pfmr_pkg::load_t    fmag_reg [0:2];
    pfmr_pkg::load_t    fmag_next [0:2];
    logic               fneg_reg [0:2];
    logic               fneg_next [0:2];
    pfmr_pkg::sum_t     sq_reg, sq_next;
    pfmr_pkg::sum_t     mul_reg, mul_next;
    logic               tneg_reg, tneg_next;
    pfmr_pkg::cross_t   cross_reg, cross_next;
    pfmr_pkg::sum_t     rem_reg, rem_next;
    pfmr_pkg::sum_t     root_reg, root_next;
    pfmr_pkg::sum_t     bit_reg, bit_next;

    // Multiplier operand selection
    pfmr_pkg::coord_t   op_a, op_b;
    logic               op_neg;
    pfmr_pkg::step_t    sq_rel, x_rel;
    logic [1:0]         x_comp, x_sub, aidx, lidx, fidx;

    // Component pairs of the cross product: i -> (i+1)%3 and (i+2)%3
    function automatic logic [1:0] comp_a(logic [1:0] c);
        logic [1:0] r;
        unique case (c)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] comp_b(logic [1:0] c);
        logic [1:0] r;
        unique case (c)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // Signed 64-bit add, clamped to the nearest bound
    function automatic sat_t sat_add64(pfmr_pkg::sum_t a, pfmr_pkg::sum_t b);
        sat_t r;
        r.val = a + b;
        r.ovf = (a[pfmr_pkg::SUM_W-1] == b[pfmr_pkg::SUM_W-1])
             && (r.val[pfmr_pkg::SUM_W-1] != a[pfmr_pkg::SUM_W-1]);
        if (r.ovf)
        begin
            r.val = a[pfmr_pkg::SUM_W-1] ? pfmr_pkg::SUM_MIN : pfmr_pkg::SUM_MAX;
        end
        return r;
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;

    // Pick the operands of the shared multiplier for the current step
    always_comb
    begin
        sq_rel = step_reg - pfmr_pkg::STEP_SQUARE0;
        x_rel  = step_reg - pfmr_pkg::STEP_CROSS0;
        x_comp = x_rel[3:2];
        x_sub  = x_rel[1:0];
        lidx   = x_sub[1] ? comp_b(x_comp) : comp_a(x_comp);
        fidx   = x_sub[1] ? comp_a(x_comp) : comp_b(x_comp);
        aidx   = (step_reg < pfmr_pkg::STEP_SQUARE0) ? step_reg[1:0] : sq_rel[1:0];
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        priority if (state_reg == S_LOAD)
        begin
            op_a = root_reg[pfmr_pkg::COORD_W-1:0];
            op_b = pressure_reg;
        end
        else if (step_reg < pfmr_pkg::STEP_SQUARE0)
        begin
            op_a   = amag_reg[aidx];
            op_b   = pressure_reg;
            op_neg = aneg_reg[aidx] ^ inward_reg;
        end
        else if (step_reg < pfmr_pkg::STEP_CROSS0)
        begin
            op_a = amag_reg[aidx];
            op_b = amag_reg[aidx];
        end
        else
        begin
            op_a   = lmag_reg[lidx];
            op_b   = x_sub[0] ? {1'b0, fmag_reg[fidx][pfmr_pkg::LOAD_W-1:pfmr_pkg::COORD_W]}
                              : fmag_reg[fidx][pfmr_pkg::COORD_W-1:0];
            // second term of the cross product is subtracted
            op_neg = lneg_reg[lidx] ^ fneg_reg[fidx] ^ x_sub[1];
        end
    end

    // Next-state logic: sequencer, product consumer, square root, output
    always_comb
    begin : next_logic
        pfmr_pkg::coord_t  area_v;
        logic [32:0]       lever_v;
        logic [32:0]       lever_abs;
        pfmr_pkg::step_t   t_rel;
        logic [1:0]        t_comp, t_sub;
        pfmr_pkg::sum_t    fval;
        pfmr_pkg::cross_t  term, base;
        logic [HI_W-1:0]   hi_bits;
        pfmr_pkg::sum_t    mval;
        sat_t              sa;
        pfmr_pkg::load_t   ld;
        pfmr_pkg::sum_t    lwide;
        logic [64:0]       diff;
        pfmr_pkg::sum_t    trial;
        logic              raise_ovf, raise_zero;

        state_next      = state_reg;
        step_next       = step_reg;
        tag_next        = tag_reg;
        tag_valid_next  = 1'b0;
        mfin_valid_next = 1'b0;
        mfin_idx_next   = mfin_idx_reg;
        pressure_next   = pressure_reg;
        inward_next     = inward_reg;
        lsum_next       = lsum_reg;
        status_next     = status_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_data_next   = out_data_reg;
        last_next       = last_reg;
        sq_next         = sq_reg;
        mul_next        = mul_reg;
        tneg_next       = tneg_reg;
        cross_next      = cross_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        for (int i = 0; i < 3; i++)
        begin
            ref_next[i]  = ref_reg[i];
            fsum_next[i] = fsum_reg[i];
            msum_next[i] = msum_reg[i];
            amag_next[i] = amag_reg[i];
            aneg_next[i] = aneg_reg[i];
            lmag_next[i] = lmag_reg[i];
            lneg_next[i] = lneg_reg[i];
            fmag_next[i] = fmag_reg[i];
            fneg_next[i] = fneg_reg[i];
        end
        raise_ovf  = 1'b0;
        raise_zero = 1'b0;
        area_v     = '0;
        lever_v    = '0;
        lever_abs  = '0;
        t_rel      = tag_reg - pfmr_pkg::STEP_CROSS0;
        t_comp     = t_rel[3:2];
        t_sub      = t_rel[1:0];
        fval       = '0;
        term       = '0;
        base       = '0;
        hi_bits    = cross_reg[pfmr_pkg::CROSS_W-1:TOP_LO];
        mval       = '0;
        sa         = '0;
        ld         = '0;
        lwide      = '0;
        diff       = '0;
        trial      = '0;

        // Drop a taken result
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pfmr_pkg::CFG_PRESSURE: pressure_next = cfg_data;
                pfmr_pkg::CFG_INWARD:   inward_next   = cfg_data[0];
                pfmr_pkg::CFG_REF_X:    ref_next[0]   = cfg_data;
                pfmr_pkg::CFG_REF_Y:    ref_next[1]   = cfg_data;
                pfmr_pkg::CFG_REF_Z:    ref_next[2]   = cfg_data;
                default:                ;
            endcase
        end

        // Consume the product issued in the previous cycle
        if (tag_valid_reg)
        begin
            priority if (tag_reg < pfmr_pkg::STEP_SQUARE0)
            begin
                // facet force component
                fmag_next[tag_reg[1:0]] = mul_reg[pfmr_pkg::LOAD_W-1:0];
                fneg_next[tag_reg[1:0]] = tneg_reg;
                fval = {1'b0, mul_reg[pfmr_pkg::LOAD_W-1:0]};
                if (tneg_reg)
                begin
                    fval = -fval;
                end
                sa = sat_add64(fsum_reg[tag_reg[1:0]], fval);
                fsum_next[tag_reg[1:0]] = sa.val;
                raise_ovf = raise_ovf | sa.ovf;
            end
            else if (tag_reg < pfmr_pkg::STEP_CROSS0)
            begin
                // sum of area squares
                sq_next = ((tag_reg == pfmr_pkg::STEP_SQUARE0) ? '0 : sq_reg) + mul_reg;
            end
            else if (tag_reg <= pfmr_pkg::STEP_CROSS_LAST)
            begin
                // cross product halves, high half weighted by 2^32
                term = t_sub[0] ? {1'b0, mul_reg, {pfmr_pkg::COORD_W{1'b0}}}
                                : {{(pfmr_pkg::CROSS_W-pfmr_pkg::SUM_W){1'b0}}, mul_reg};
                base = (t_sub == 2'd0) ? '0 : cross_reg;
                cross_next = tneg_reg ? (base - term) : (base + term);
                if (t_sub == 2'd3)
                begin
                    mfin_valid_next = 1'b1;
                    mfin_idx_next   = t_comp;
                end
            end
            else
            begin
                // normal load, clamped then added
                ld = mul_reg[pfmr_pkg::SUM_W-1] ? pfmr_pkg::LOAD_MAX
                                                : mul_reg[pfmr_pkg::LOAD_W-1:0];
                raise_ovf = raise_ovf | mul_reg[pfmr_pkg::SUM_W-1];
                lwide = {1'b0, lsum_reg} + {1'b0, ld};
                if (lwide[pfmr_pkg::SUM_W-1])
                begin
                    raise_ovf = 1'b1;
                    lsum_next = pfmr_pkg::LOAD_MAX;
                end
                else
                begin
                    lsum_next = lwide[pfmr_pkg::LOAD_W-1:0];
                end
            end
        end

        // Finish a moment component: floor shift, clamp, accumulate
        if (mfin_valid_reg)
        begin
            if ((&hi_bits) || !(|hi_bits))
            begin
                mval = cross_reg[TOP_LO:FRAC_BITS];
            end
            else
            begin
                raise_ovf = 1'b1;
                mval = cross_reg[pfmr_pkg::CROSS_W-1] ? pfmr_pkg::SUM_MIN : pfmr_pkg::SUM_MAX;
            end
            sa = sat_add64(msum_reg[mfin_idx_reg], mval);
            msum_next[mfin_idx_reg] = sa.val;
            raise_ovf = raise_ovf | sa.ovf;
        end

        // Sequencer
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        area_v       = s_tdata[pfmr_pkg::COORD_W*i +: pfmr_pkg::COORD_W];
                        aneg_next[i] = area_v[pfmr_pkg::COORD_W-1];
                        amag_next[i] = area_v[pfmr_pkg::COORD_W-1] ? -area_v : area_v;
                        lever_v = {s_tdata[pfmr_pkg::COORD_W*(i+3) + pfmr_pkg::COORD_W-1],
                                   s_tdata[pfmr_pkg::COORD_W*(i+3) +: pfmr_pkg::COORD_W]}
                                - {ref_reg[i][pfmr_pkg::COORD_W-1], ref_reg[i]};
                        lever_abs    = lever_v[pfmr_pkg::COORD_W] ? -lever_v : lever_v;
                        lneg_next[i] = lever_v[pfmr_pkg::COORD_W];
                        lmag_next[i] = lever_abs[pfmr_pkg::COORD_W-1:0];
                    end
                    last_next  = s_tlast;
                    raise_zero = (s_tdata[3*pfmr_pkg::COORD_W-1:0] == '0);
                    step_next  = pfmr_pkg::STEP_FORCE0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // issue one product per cycle
                mul_next       = {{pfmr_pkg::COORD_W{1'b0}}, op_a}
                               * {{pfmr_pkg::COORD_W{1'b0}}, op_b};
                tneg_next      = op_neg;
                tag_next       = step_reg;
                tag_valid_next = 1'b1;
                step_next      = step_reg + 5'd1;
                if (step_reg == pfmr_pkg::STEP_CROSS_LAST)
                begin
                    rem_next   = sq_reg;
                    root_next  = '0;
                    bit_next   = {2'b01, {(pfmr_pkg::SUM_W-2){1'b0}}};
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // one root bit per cycle
                trial = root_reg + bit_reg;
                diff  = {1'b0, rem_reg} - {1'b0, trial};
                if (!diff[pfmr_pkg::SUM_W])
                begin
                    rem_next  = diff[pfmr_pkg::SUM_W-1:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                mul_next       = {{pfmr_pkg::COORD_W{1'b0}}, op_a}
                               * {{pfmr_pkg::COORD_W{1'b0}}, op_b};
                tneg_next      = 1'b0;
                tag_next       = pfmr_pkg::STEP_LOAD;
                tag_valid_next = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!m_tvalid_reg || m_tready)
                begin
                    // emit totals and clear the run
                    out_data_next = {{(pfmr_pkg::OUT_DATA_W-pfmr_pkg::OUT_USED_W){1'b0}},
                                     status_reg, lsum_reg,
                                     msum_reg[2], msum_reg[1], msum_reg[0],
                                     fsum_reg[2], fsum_reg[1], fsum_reg[0]};
                    m_tvalid_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        fsum_next[i] = '0;
                        msum_next[i] = '0;
                    end
                    lsum_next  = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Sticky status, overflow dominates zero area
        if (state_reg == S_WRAP && last_reg && (!m_tvalid_reg || m_tready))
        begin
            status_next = pfmr_pkg::ST_OK;
        end
        else if (raise_ovf)
        begin
            status_next = pfmr_pkg::ST_OVERFLOW;
        end
        else if (raise_zero && status_reg == pfmr_pkg::ST_OK)
        begin
            status_next = pfmr_pkg::ST_ZERO_AREA;
        end
    end

    // State, sums, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            tag_reg        <= '0;
            tag_valid_reg  <= 1'b0;
            mfin_valid_reg <= 1'b0;
            mfin_idx_reg   <= '0;
            pressure_reg   <= '0;
            inward_reg     <= 1'b0;
            lsum_reg       <= '0;
            status_reg     <= pfmr_pkg::ST_OK;
            m_tvalid_reg   <= 1'b0;
            out_data_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                ref_reg[i]  <= '0;
                fsum_reg[i] <= '0;
                msum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            tag_reg        <= tag_next;
            tag_valid_reg  <= tag_valid_next;
            mfin_valid_reg <= mfin_valid_next;
            mfin_idx_reg   <= mfin_idx_next;
            pressure_reg   <= pressure_next;
            inward_reg     <= inward_next;
            lsum_reg       <= lsum_next;
            status_reg     <= status_next;
            m_tvalid_reg   <= m_tvalid_next;
            out_data_reg   <= out_data_next;
            for (int i = 0; i < 3; i++)
            begin
                ref_reg[i]  <= ref_next[i];
                fsum_reg[i] <= fsum_next[i];
                msum_reg[i] <= msum_next[i];
            end
        end
    end

    // Facet operands, products and square root working registers
    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        sq_reg    <= sq_next;
        mul_reg   <= mul_next;
        tneg_reg  <= tneg_next;
        cross_reg <= cross_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        for (int i = 0; i < 3; i++)
        begin
            amag_reg[i] <= amag_next[i];
            aneg_reg[i] <= aneg_next[i];
            lmag_reg[i] <= lmag_next[i];
            lneg_reg[i] <= lneg_next[i];
            fmag_reg[i] <= fmag_next[i];
            fneg_reg[i] <= fneg_next[i];
        end
    end

endmodule

/* hdl/pfmr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfmr_checker - port-level checks for the pressure resultant block
// Watches the stream ports for busy behavior, result framing and stalls.
// ----------------------------------------------------------------------------
module pfmr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pfmr_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Busy right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while the previous facet is in progress");

    // A new result appears only as the sequencer returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised outside the end of a facet");

    // Status carries only defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[pfmr_pkg::OUT_STATUS_LSB +: 2] == pfmr_pkg::ST_OK
                   || m_tdata[pfmr_pkg::OUT_STATUS_LSB +: 2] == pfmr_pkg::ST_ZERO_AREA
                   || m_tdata[pfmr_pkg::OUT_STATUS_LSB +: 2] == pfmr_pkg::ST_OVERFLOW))
        else $error("undefined status code on output");

    // Zero fill above the packed fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[pfmr_pkg::OUT_DATA_W-1:pfmr_pkg::OUT_USED_W] == '0))
        else $error("output fill bits not zero");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

endmodule

bind pressure_force_moment_resultant pfmr_checker u_pfmr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/pressure_force_moment_resultant_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_force_moment_resultant_test - facet stream resultant testbench
// Feeds surface facets to the block, keeps its own running force, moment
// and load totals per surface run, and compares every emitted total field by
// field. Covers reset defaults, plain runs, zero-area facets, saturation,
// unused register indexes, a long output stall and random runs under
// three idling mixes on both stream sides.
// ----------------------------------------------------------------------------
module pressure_force_moment_resultant_test;
    import pfmr_pkg::*;

    localparam int FRAC           = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 20;

    localparam coord_t ONE     = 32'h0001_0000;
    localparam coord_t HALF    = 32'h0000_8000;
    localparam coord_t NEG_TWO = 32'hFFFE_0000;
    localparam coord_t CMAX    = 32'h7FFF_FFFF;
    localparam coord_t CMIN    = 32'h8000_0000;

    // One facet, area components in the low bits of the packed vector
    typedef struct packed {
        logic         last;
        coord_t [2:0] cent;
        coord_t [2:0] area;
    } facet_t;

    // One emitted total, laid out as the low bits of m_tdata
    typedef struct packed {
        status_t    status;
        load_t      load;
        sum_t [2:0] moment;
        sum_t [2:0] force_sum;
    } totals_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted block state and settings
    logic [31:0] pressure_q;
    logic        inward_q;
    coord_t [2:0] refp_q;
    sum_t [2:0]  force_acc;
    sum_t [2:0]  moment_acc;
    logic [63:0] load_acc;
    status_t     run_st;

    totals_t totals_due [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_request;
    int hold_left;
    int fail_count;
    int facets_sent;
    int totals_checked;
    int cfg_writes;
    int stall_cycles;

    pressure_force_moment_resultant #(
        .FRAC_BITS (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void raise_status(status_t s);
        if (s > run_st)
            run_st = s;
    endfunction

    // Signed 64-bit add that clamps to the nearest bound
    function automatic sum_t add_clamped(sum_t a, sum_t b);
        sum_t s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            raise_status(ST_OVERFLOW);
            return a[63] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

    // Accumulate one facet; queue the totals when it closes a run
    function automatic void absorb_facet(facet_t f);
        logic [31:0]         mag;
        logic [63:0]         sq_sum;
        logic [63:0]         root;
        logic [63:0]         trial;
        logic [63:0]         facet_load;
        logic signed [32:0]  lever [3];
        sum_t                facet_force [3];
        sum_t                facet_moment;
        logic signed [127:0] la, lb, fa, fb, cross_prod, scaled;
        totals_t             t;
        int                  i, a, b;

        sq_sum = '0;
        for (i = 0; i < 3; i++)
        begin
            mag = f.area[i][31] ? -f.area[i] : f.area[i];
            lever[i] = $signed({f.cent[i][31], f.cent[i]})
                     - $signed({refp_q[i][31], refp_q[i]});
            sq_sum += 64'(mag) * 64'(mag);
            facet_force[i] = 64'(mag) * 64'(pressure_q);
            if (f.area[i][31] != inward_q)
                facet_force[i] = -facet_force[i];
        end

        if (sq_sum == '0)
            raise_status(ST_ZERO_AREA);

        // Floor square root, one result bit at a time
        root = '0;
        for (i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= sq_sum)
                root = trial;
        end

        facet_load = root * 64'(pressure_q);
        if (facet_load > 64'(LOAD_MAX))
        begin
            raise_status(ST_OVERFLOW);
            facet_load = 64'(LOAD_MAX);
        end
        load_acc += facet_load;
        if (load_acc > 64'(LOAD_MAX))
        begin
            raise_status(ST_OVERFLOW);
            load_acc = 64'(LOAD_MAX);
        end

        // Moment = lever x force, scaled back to Q16.16 with floor
        for (i = 0; i < 3; i++)
        begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            la = lever[a];
            lb = lever[b];
            fa = $signed(facet_force[a]);
            fb = $signed(facet_force[b]);
            cross_prod = la * fb - lb * fa;
            scaled = cross_prod >>> FRAC;
            if (scaled[127:63] == '0 || scaled[127:63] == '1)
                facet_moment = scaled[63:0];
            else
            begin
                raise_status(ST_OVERFLOW);
                facet_moment = cross_prod[127] ? SUM_MIN : SUM_MAX;
            end
            force_acc[i]  = add_clamped(force_acc[i], facet_force[i]);
            moment_acc[i] = add_clamped(moment_acc[i], facet_moment);
        end

        if (f.last)
        begin
            t.force_sum = force_acc;
            t.moment    = moment_acc;
            t.load      = load_acc[LOAD_W-1:0];
            t.status    = run_st;
            totals_due.push_back(t);
            force_acc  = '0;
            moment_acc = '0;
            load_acc   = '0;
            run_st     = ST_OK;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s expected %h got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_totals
        totals_t want;
        totals_t got;
        int      j;
        if (m_tvalid && m_tready)
        begin
            if (totals_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: result with none expected: %h", $time, m_tdata);
            end
            else
            begin
                want = totals_due.pop_front();
                got  = m_tdata[OUT_USED_W-1:0];
                for (j = 0; j < 3; j++)
                begin
                    check_field($sformatf("force[%0d]", j), want.force_sum[j],
                                got.force_sum[j]);
                    check_field($sformatf("moment[%0d]", j), want.moment[j], got.moment[j]);
                end
                check_field("normal_load", 64'(want.load), 64'(got.load));
                check_field("status", 64'(want.status), 64'(got.status));
                totals_checked++;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one facet, with an occasional gap first
    task automatic send_facet(facet_t f);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 60) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {f.cent, f.area};
        s_tlast  <= f.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_facet(f);
        facets_sent++;
    endtask

    // Stop offering and hold until every queued total has arrived
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (totals_due.size() != 0)
            @(posedge clk);
    endtask

    // Let the block go fully idle, including a facet with no result
    task automatic wait_drained();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PRESSURE: pressure_q = value;
            CFG_INWARD:   inward_q   = value[0];
            CFG_REF_X:    refp_q[0]  = value;
            CFG_REF_Y:    refp_q[1]  = value;
            CFG_REF_Z:    refp_q[2]  = value;
            default:      ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_settings(logic [31:0] pressure, logic [31:0] inw,
                                  coord_t rx, coord_t ry, coord_t rz);
        wait_drained();
        write_reg(CFG_PRESSURE, pressure);
        write_reg(CFG_INWARD, inw);
        write_reg(CFG_REF_X, rx);
        write_reg(CFG_REF_Y, ry);
        write_reg(CFG_REF_Z, rz);
        cfg_valid <= 1'b0;
    endtask

    function automatic facet_t make_facet(coord_t ax, coord_t ay, coord_t az,
                                          coord_t cx, coord_t cy, coord_t cz,
                                          logic last);
        facet_t f;
        f.area = {az, ay, ax};
        f.cent = {cz, cy, cx};
        f.last = last;
        return f;
    endfunction

    // Mostly spread magnitudes, sometimes the extremes
    function automatic coord_t random_coord();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0: v = CMAX;
            1: v = CMIN;
            2: v = '0;
            3: v = '1;
            default: v = $signed(v) >>> $urandom_range(0, 20);
        endcase
        return v;
    endfunction

    function automatic facet_t random_facet(logic last);
        facet_t f;
        int i;
        for (i = 0; i < 3; i++)
        begin
            f.area[i] = random_coord();
            f.cent[i] = random_coord();
        end
        if ($urandom_range(24) == 0)
            f.area = '0;
        f.last = last;
        return f;
    endfunction

    task automatic apply_random_settings();
        logic [31:0] pressure;
        case ($urandom_range(5))
            0: pressure = '0;
            1: pressure = '1;
            default: pressure = $urandom() >> $urandom_range(0, 31);
        endcase
        apply_settings(pressure, $urandom(), random_coord(), random_coord(), random_coord());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: zero pressure gives zero totals
    task automatic test_reset_defaults();
        send_facet(make_facet(ONE, HALF, NEG_TWO, ONE, ONE, ONE, 1'b1));
    endtask

    task automatic test_basic_facets();
        apply_settings(32'd1000, 32'd0, '0, '0, '0);
        send_facet(make_facet(ONE, '0, '0, ONE, ONE, '0, 1'b0));
        send_facet(make_facet('0, NEG_TWO, '0, '0, '0, ONE, 1'b0));
        send_facet(make_facet('0, '0, HALF, HALF, NEG_TWO, ONE, 1'b1));
        // Inward pressure about an offset reference point
        apply_settings(32'd101325, 32'd1, HALF, NEG_TWO, ONE);
        send_facet(make_facet(ONE, ONE, ONE, '0, '0, '0, 1'b0));
        send_facet(make_facet(NEG_TWO, HALF, '0, ONE, ONE, ONE, 1'b1));
    endtask

    // Zero area alone, inside a run, then a clean run to clear the status
    task automatic test_zero_area();
        send_facet(make_facet('0, '0, '0, ONE, ONE, ONE, 1'b1));
        send_facet(make_facet('0, '0, '0, HALF, '0, '0, 1'b0));
        send_facet(make_facet(ONE, '0, HALF, '0, ONE, '0, 1'b0));
        send_facet(make_facet(HALF, ONE, '0, '0, '0, ONE, 1'b1));
        send_facet(make_facet(ONE, ONE, '0, ONE, '0, ONE, 1'b1));
    endtask

    task automatic test_overflow();
        apply_settings('1, 32'd0, CMIN, CMAX, CMIN);
        // Load and moment saturate on one facet
        send_facet(make_facet(CMAX, CMIN, CMAX, CMAX, CMIN, CMAX, 1'b1));
        // Force sum runs past the bound over two facets
        send_facet(make_facet(CMIN, '0, '0, '0, '0, '0, 1'b0));
        send_facet(make_facet(CMIN, '0, '0, '0, '0, '0, 1'b1));
        // Zero area and overflow together: overflow wins
        send_facet(make_facet('0, '0, '0, '0, '0, '0, 1'b0));
        send_facet(make_facet(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b1));
        apply_settings('1, 32'd1, CMAX, CMIN, CMAX);
        send_facet(make_facet(CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, 1'b1));
        send_facet(make_facet(ONE, '0, '0, CMAX, CMIN, CMAX, 1'b1));
    endtask

    // Writes past the last register must change nothing
    task automatic test_register_index();
        int k;
        wait_drained();
        for (k = int'(CFG_REF_Z) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(cfg_idx_t'(k), $urandom());
        cfg_valid <= 1'b0;
        send_facet(make_facet(ONE, HALF, NEG_TWO, ONE, '0, '0, 1'b0));
        send_facet(make_facet(NEG_TWO, ONE, HALF, '0, ONE, '0, 1'b1));
    endtask

    // Hold the output off while facets keep coming, so the input stalls
    task automatic test_output_backpressure();
        int k;
        apply_settings(32'd5000, 32'd0, HALF, HALF, HALF);
        hold_request = HOLD_CYCLES;
        for (k = 0; k < 10; k++)
            send_facet(random_facet(1'b1));
        wait_drained();
    endtask

    task automatic test_random_runs(int send_pct, int recv_pct, int items);
        int sent, seg_end, run_len, k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < items)
        begin
            apply_random_settings();
            seg_end = sent + $urandom_range(60, 120);
            while (sent < seg_end && sent < items)
            begin
                run_len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 8);
                for (k = 1; k <= run_len; k++)
                begin
                    if ($urandom_range(39) == 0)
                        wait_results();
                    send_facet(random_facet(k == run_len));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PRESSURE;
        cfg_data  <= '0;

        pressure_q     = '0;
        inward_q       = 1'b0;
        refp_q         = '0;
        force_acc      = '0;
        moment_acc     = '0;
        load_acc       = '0;
        run_st         = ST_OK;
        hold_request   = 0;
        hold_left      = 0;
        fail_count     = 0;
        facets_sent    = 0;
        totals_checked = 0;
        cfg_writes     = 0;
        send_idle_pct  = 9;
        recv_idle_pct  = 47;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_basic_facets();
        test_zero_area();
        test_overflow();
        test_register_index();
        test_output_backpressure();
        test_random_runs(9, 47, 300);
        test_random_runs(47, 9, 300);
        test_random_runs(0, 0, 300);
        wait_drained();

        $display("Covered %0d facets, %0d surface totals checked, %0d register writes,",
                 facets_sent, totals_checked, cfg_writes);
        $display("zero-area and saturation runs, unused indexes, output hold-off; %0d errors",
                 fail_count);
        if (fail_count == 0 && totals_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
